/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the flux core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed: property violated");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("assertion failed: forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* src/phf_pkg.sv */
// ----------------------------------------------------------------------------
// phf_pkg
// Shared constants and the face-state transaction type.
// ----------------------------------------------------------------------------
`default_nettype none
package phf_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH        = 4;
	localparam int QLW           = $clog2(QDEPTH + 1);
	localparam int QPW           = $clog2(QDEPTH);
	localparam int DIV_STEPS     = 32;
	localparam int MAGW          = 129;

	typedef struct packed {
		logic               dir;
		logic [30:0]        rho_l;
		logic [30:0]        rho_r;
		logic signed [31:0] vx_l;
		logic signed [31:0] vy_l;
		logic signed [31:0] vx_r;
		logic signed [31:0] vy_r;
		logic signed [31:0] vn_l;
		logic signed [31:0] vn_r;
		logic [31:0]        ap;
		logic [31:0]        amn;
	} phf_face_t;
endpackage
`default_nettype wire

/* src/phf_front.sv */
// ----------------------------------------------------------------------------
// phf_front
// Accepts stencils, forms limited slopes, face states and wave speeds.
// ----------------------------------------------------------------------------
`default_nettype none
module phf_front import phf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               dir,
	input  logic [30:0]        far_left_density,
	input  logic signed [31:0] far_left_vel_x,
	input  logic signed [31:0] far_left_vel_y,
	input  logic [30:0]        left_density,
	input  logic signed [31:0] left_vel_x,
	input  logic signed [31:0] left_vel_y,
	input  logic [30:0]        right_density,
	input  logic signed [31:0] right_vel_x,
	input  logic signed [31:0] right_vel_y,
	input  logic [30:0]        far_right_density,
	input  logic signed [31:0] far_right_vel_x,
	input  logic signed [31:0] far_right_vel_y,
	input  logic [QLW-1:0]     level,
	output logic               push,
	output phf_face_t          item
);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	function automatic logic signed [33:0] face_off(input logic signed [32:0] yl,
		input logic signed [32:0] y0, input logic signed [32:0] yr);
		logic signed [33:0] dl, dr, dw;
		logic signed [35:0] a, b, c;
		logic [34:0] ma, mb, mc, m;
		logic pos, neg;
		dl = 34'(y0) - 34'(yl);
		dr = 34'(yr) - 34'(y0);
		dw = 34'(yr) - 34'(yl);
		a = 36'(dl) + (36'(dl) <<< 1);
		b = 36'(dw);
		c = 36'(dr) + (36'(dr) <<< 1);
		ma = a[35] ? 35'(-a) : a[34:0];
		mb = b[35] ? 35'(-b) : b[34:0];
		mc = c[35] ? 35'(-c) : c[34:0];
		m = ma;
		if (mb < m) m = mb;
		if (mc < m) m = mc;
		pos = !a[35] && (a != '0) && !b[35] && (b != '0) && !c[35] && (c != '0);
		neg = a[35] && b[35] && c[35];
		if (pos) return $signed({1'b0, m[34:2]});
		else if (neg) return -$signed({1'b0, m[34:2]});
		else return '0;
	endfunction

	logic signed [32:0] cells [4][3];
	logic               accept;
	logic [QLW:0]       pending;

	logic               v_s1;
	logic               dir_s1;
	logic signed [33:0] off_l_s1 [3];
	logic signed [33:0] off_r_s1 [3];
	logic signed [32:0] cl_s1 [3];
	logic signed [32:0] cr_s1 [3];

	logic signed [33:0] fs_l [3];
	logic signed [33:0] fs_r [3];
	logic signed [31:0] vn_l, vn_r;
	logic signed [33:0] vpl, vpr, vml, vmr, apw, amw;
	phf_face_t          item_d;

	logic               v_s2;
	phf_face_t          item_s2;

	always_comb begin
		cells[0][0] = {2'b00, far_left_density};
		cells[0][1] = {far_left_vel_x[31], far_left_vel_x};
		cells[0][2] = {far_left_vel_y[31], far_left_vel_y};
		cells[1][0] = {2'b00, left_density};
		cells[1][1] = {left_vel_x[31], left_vel_x};
		cells[1][2] = {left_vel_y[31], left_vel_y};
		cells[2][0] = {2'b00, right_density};
		cells[2][1] = {right_vel_x[31], right_vel_x};
		cells[2][2] = {right_vel_y[31], right_vel_y};
		cells[3][0] = {2'b00, far_right_density};
		cells[3][1] = {far_right_vel_x[31], far_right_vel_x};
		cells[3][2] = {far_right_vel_y[31], far_right_vel_y};
	end

	// credit check: queue level plus items still in the front
	assign pending = (QLW+1)'(level) + (QLW+1)'(v_s1) + (QLW+1)'(v_s2);
	assign busy    = pending >= (QLW+1)'(QDEPTH);
	assign accept  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dir_s1 <= dir;
		for (int q = 0; q < 3; q++) begin
			off_l_s1[q] <= face_off(cells[0][q], cells[1][q], cells[2][q]);
			off_r_s1[q] <= face_off(cells[1][q], cells[2][q], cells[3][q]);
			cl_s1[q]    <= cells[1][q];
			cr_s1[q]    <= cells[2][q];
		end
		item_s2 <= item_d;
	end

	always_comb begin
		for (int q = 0; q < 3; q++) begin
			fs_l[q] = 34'(cl_s1[q]) + off_l_s1[q];
			fs_r[q] = 34'(cr_s1[q]) - off_r_s1[q];
		end
		vn_l = dir_s1 ? fs_l[2][31:0] : fs_l[1][31:0];
		vn_r = dir_s1 ? fs_r[2][31:0] : fs_r[1][31:0];
		vpl = 34'(vn_l) + 34'(ONE);
		vpr = 34'(vn_r) + 34'(ONE);
		vml = 34'(ONE) - 34'(vn_l);
		vmr = 34'(ONE) - 34'(vn_r);
		apw = '0;
		if (vpl > apw) apw = vpl;
		if (vpr > apw) apw = vpr;
		amw = '0;
		if (vml > amw) amw = vml;
		if (vmr > amw) amw = vmr;
		item_d.dir   = dir_s1;
		item_d.rho_l = fs_l[0][30:0];
		item_d.rho_r = fs_r[0][30:0];
		item_d.vx_l  = fs_l[1][31:0];
		item_d.vy_l  = fs_l[2][31:0];
		item_d.vx_r  = fs_r[1][31:0];
		item_d.vy_r  = fs_r[2][31:0];
		item_d.vn_l  = vn_l;
		item_d.vn_r  = vn_r;
		item_d.ap    = apw[31:0];
		item_d.amn   = amw[31:0];
	end

	assign push = v_s2;
	assign item = item_s2;
endmodule
`default_nettype wire

/* src/phf_queue.sv */
// ----------------------------------------------------------------------------
// phf_queue
// Short FIFO of face states between the front and the flux pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module phf_queue import phf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  phf_face_t      push_item,
	output logic           pop,
	output phf_face_t      pop_item,
	output logic [QLW-1:0] level
);
	phf_face_t      mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLW-1:0] level_q;

	assign pop      = level_q != '0;
	assign pop_item = mem_q[rd_ptr_q];
	assign level    = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= QPW'(wr_ptr_q + 1'b1);
			if (pop) rd_ptr_q <= QPW'(rd_ptr_q + 1'b1);
			level_q <= QLW'(level_q + QLW'(push) - QLW'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	`ASSERT_NEVER(a_q_overflow, clk, arst_n, push && !pop && (level_q == QLW'(QDEPTH)))
	`ASSERT_NEVER(a_q_drained, clk, arst_n, level_q > QLW'(1))
endmodule
`default_nettype wire

/* src/phf_div.sv */
// ----------------------------------------------------------------------------
// phf_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module phf_div import phf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_neg,
	input  logic [MAGW-1:0]    in_mag,
	input  logic [32:0]        in_den,
	output logic               out_valid,
	output logic signed [31:0] out_res
);
	localparam int MW = MAGW - 2 * FRAC_BITS;

	logic [MW-1:0]    msh;
	logic [MW-33:0]   hi;

	logic             vld_q [DIV_STEPS+1];
	logic             neg_q [DIV_STEPS+1];
	logic             sat_q [DIV_STEPS+1];
	logic [32:0]      den_q [DIV_STEPS+1];
	logic [32:0]      rem_q [DIV_STEPS+1];
	logic [31:0]      low_q [DIV_STEPS+1];
	logic [31:0]      quo_q [DIV_STEPS+1];
	logic [33:0]      trial [DIV_STEPS];
	logic             ge [DIV_STEPS];

	logic             done_q;
	logic signed [31:0] res_q;
	logic [31:0]      qf;
	logic             ovf;

	assign msh = in_mag[MAGW-1:2*FRAC_BITS];
	assign hi  = msh[MW-1:32];

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial[k] = {rem_q[k], low_q[k][31]};
			ge[k]    = trial[k] >= {1'b0, den_q[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) vld_q[k] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
			for (int k = 0; k < DIV_STEPS; k++) vld_q[k+1] <= vld_q[k];
			done_q <= vld_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		neg_q[0] <= in_neg;
		sat_q[0] <= hi >= (MW-32)'(in_den);
		den_q[0] <= in_den;
		rem_q[0] <= hi[32:0];
		low_q[0] <= msh[31:0];
		quo_q[0] <= '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			neg_q[k+1] <= neg_q[k];
			sat_q[k+1] <= sat_q[k];
			den_q[k+1] <= den_q[k];
			rem_q[k+1] <= ge[k] ? 33'(trial[k] - {1'b0, den_q[k]}) : trial[k][32:0];
			low_q[k+1] <= {low_q[k][30:0], 1'b0};
			quo_q[k+1] <= {quo_q[k][30:0], ge[k]};
		end
		res_q <= ovf ? (neg_q[DIV_STEPS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
			: (neg_q[DIV_STEPS] ? -$signed(qf) : $signed(qf));
	end

	assign qf  = quo_q[DIV_STEPS];
	assign ovf = sat_q[DIV_STEPS] || (neg_q[DIV_STEPS] ? (qf > 32'h8000_0000) : qf[31]);

	assign out_valid = done_q;
	assign out_res   = res_q;

	`ASSERT_PROP(a_rem_bound, clk, arst_n, vld_q[DIV_STEPS] && !sat_q[DIV_STEPS] |-> rem_q[DIV_STEPS] < den_q[DIV_STEPS])
endmodule
`default_nettype wire

/* src/phf_back.sv */
// ----------------------------------------------------------------------------
// phf_back
// HLLE flux pipeline: products, signed sum, then divide by the wave span.
// ----------------------------------------------------------------------------
`default_nettype none
module phf_back import phf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  phf_face_t          in_item,
	output logic               out_valid,
	output logic signed [31:0] mass_flux,
	output logic signed [31:0] x_momentum_flux,
	output logic signed [31:0] y_momentum_flux
);
	localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [31:0] w_l [3];
	logic signed [31:0] w_r [3];

	// s1
	logic signed [63:0] inner_s1 [2][3];
	logic signed [63:0] cons_s1 [2][3];
	logic [63:0] apam_s1;
	logic [31:0] ap_s1, amn_s1;
	logic [32:0] d_s1;
	logic        dir_s1;
	logic [30:0] rho_s1 [2];
	// s2
	logic signed [63:0] adj [2][3];
	logic signed [64:0] diff [3];
	logic [62:0] imag_s2 [2][3];
	logic        ineg_s2 [2][3];
	logic [63:0] dmag_s2 [3];
	logic        dneg_s2 [3];
	logic [63:0] apam_s2;
	logic [31:0] ap_s2, amn_s2;
	logic [32:0] d_s2;
	logic [30:0] rho_s2 [2];
	// s3
	logic [62:0] plo_s3 [2][3];
	logic [61:0] phi_s3 [2][3];
	logic [63:0] ll_s3 [3];
	logic [63:0] lh_s3 [3];
	logic [63:0] hl_s3 [3];
	logic [63:0] hh_s3 [3];
	logic        ineg_s3 [2][3];
	logic        dneg_s3 [3];
	logic [31:0] ap_s3, amn_s3;
	logic [32:0] d_s3;
	// s4
	logic [93:0]  p_s4 [2][3];
	logic [127:0] t3_s4 [3];
	logic         ineg_s4 [2][3];
	logic         dneg_s4 [3];
	logic [31:0]  ap_s4, amn_s4;
	logic [32:0]  d_s4;
	logic [64:0]  mid [3];
	// s5
	logic [63:0]  c0_s5 [2][3];
	logic [63:0]  c1_s5 [2][3];
	logic [61:0]  c2_s5 [2][3];
	logic [127:0] t3_s5 [3];
	logic         ineg_s5 [2][3];
	logic         dneg_s5 [3];
	logic [32:0]  d_s5;
	logic [31:0]  mul_m [2];
	// s6
	logic [125:0] t_s6 [2][3];
	logic [127:0] t3_s6 [3];
	logic         ineg_s6 [2][3];
	logic         dneg_s6 [3];
	logic [32:0]  d_s6;
	// s7
	logic signed [127:0] s12_s7 [3];
	logic [127:0] t3_s7 [3];
	logic         dneg_s7 [3];
	logic [32:0]  d_s7;
	// s8
	logic signed [129:0] n_s8 [3];
	logic [32:0]  d_s8;
	// s9
	logic [MAGW-1:0] mag_s9 [3];
	logic        neg_s9 [3];
	logic [32:0] d_s9;

	logic signed [31:0] res [3];

	always_comb begin
		w_l[0] = ONE;
		w_l[1] = in_item.vx_l;
		w_l[2] = in_item.vy_l;
		w_r[0] = ONE;
		w_r[1] = in_item.vx_r;
		w_r[2] = in_item.vy_r;
		mul_m[0] = ap_s4;
		mul_m[1] = amn_s4;
		for (int q = 0; q < 3; q++) begin
			for (int s = 0; s < 2; s++) begin
				adj[s][q] = inner_s1[s][q] +
					(((q == 1 && !dir_s1) || (q == 2 && dir_s1)) ? ONE2 : 64'sd0);
			end
			diff[q] = 65'(cons_s1[0][q]) - 65'(cons_s1[1][q]);
			mid[q]  = 65'(lh_s3[q]) + 65'(hl_s3[q]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		// s1: products of normal velocity and density with each component
		for (int q = 0; q < 3; q++) begin
			inner_s1[0][q] <= in_item.vn_l * w_l[q];
			inner_s1[1][q] <= in_item.vn_r * w_r[q];
			cons_s1[0][q]  <= $signed({1'b0, in_item.rho_l}) * w_l[q];
			cons_s1[1][q]  <= $signed({1'b0, in_item.rho_r}) * w_r[q];
		end
		apam_s1   <= in_item.ap * in_item.amn;
		ap_s1     <= in_item.ap;
		amn_s1    <= in_item.amn;
		d_s1      <= 33'(in_item.ap) + 33'(in_item.amn);
		dir_s1    <= in_item.dir;
		rho_s1[0] <= in_item.rho_l;
		rho_s1[1] <= in_item.rho_r;

		// s2: pressure term, magnitudes and signs
		for (int q = 0; q < 3; q++) begin
			for (int s = 0; s < 2; s++) begin
				ineg_s2[s][q] <= adj[s][q][63];
				imag_s2[s][q] <= adj[s][q][63] ? 63'(-adj[s][q]) : adj[s][q][62:0];
			end
			dneg_s2[q] <= diff[q][64];
			dmag_s2[q] <= diff[q][64] ? 64'(-diff[q]) : diff[q][63:0];
		end
		apam_s2 <= apam_s1;
		ap_s2   <= ap_s1;
		amn_s2  <= amn_s1;
		d_s2    <= d_s1;
		rho_s2  <= rho_s1;

		// s3: partial products
		for (int q = 0; q < 3; q++) begin
			for (int s = 0; s < 2; s++) begin
				plo_s3[s][q]  <= rho_s2[s] * imag_s2[s][q][31:0];
				phi_s3[s][q]  <= rho_s2[s] * imag_s2[s][q][62:32];
				ineg_s3[s][q] <= ineg_s2[s][q];
			end
			ll_s3[q]   <= dmag_s2[q][31:0] * apam_s2[31:0];
			lh_s3[q]   <= dmag_s2[q][31:0] * apam_s2[63:32];
			hl_s3[q]   <= dmag_s2[q][63:32] * apam_s2[31:0];
			hh_s3[q]   <= dmag_s2[q][63:32] * apam_s2[63:32];
			dneg_s3[q] <= dneg_s2[q];
		end
		ap_s3  <= ap_s2;
		amn_s3 <= amn_s2;
		d_s3   <= d_s2;

		// s4: recombine
		for (int q = 0; q < 3; q++) begin
			for (int s = 0; s < 2; s++) begin
				p_s4[s][q]    <= 94'(plo_s3[s][q]) + {phi_s3[s][q], 32'b0};
				ineg_s4[s][q] <= ineg_s3[s][q];
			end
			t3_s4[q]   <= {hh_s3[q], ll_s3[q]} + {31'b0, mid[q], 32'b0};
			dneg_s4[q] <= dneg_s3[q];
		end
		ap_s4  <= ap_s3;
		amn_s4 <= amn_s3;
		d_s4   <= d_s3;

		// s5: scale by wave speeds
		for (int q = 0; q < 3; q++) begin
			for (int s = 0; s < 2; s++) begin
				c0_s5[s][q]   <= p_s4[s][q][31:0] * mul_m[s];
				c1_s5[s][q]   <= p_s4[s][q][63:32] * mul_m[s];
				c2_s5[s][q]   <= p_s4[s][q][93:64] * mul_m[s];
				ineg_s5[s][q] <= ineg_s4[s][q];
			end
			t3_s5[q]   <= t3_s4[q];
			dneg_s5[q] <= dneg_s4[q];
		end
		d_s5 <= d_s4;

		// s6
		for (int q = 0; q < 3; q++) begin
			for (int s = 0; s < 2; s++) begin
				t_s6[s][q]    <= {c2_s5[s][q], c0_s5[s][q]} + {30'b0, c1_s5[s][q], 32'b0};
				ineg_s6[s][q] <= ineg_s5[s][q];
			end
			t3_s6[q]   <= t3_s5[q];
			dneg_s6[q] <= dneg_s5[q];
		end
		d_s6 <= d_s5;

		// s7
		for (int q = 0; q < 3; q++) begin
			s12_s7[q] <= (ineg_s6[0][q] ? -$signed(128'(t_s6[0][q])) : $signed(128'(t_s6[0][q])))
				+ (ineg_s6[1][q] ? -$signed(128'(t_s6[1][q])) : $signed(128'(t_s6[1][q])));
			t3_s7[q]   <= t3_s6[q];
			dneg_s7[q] <= dneg_s6[q];
		end
		d_s7 <= d_s6;

		// s8
		for (int q = 0; q < 3; q++) begin
			n_s8[q] <= 130'(s12_s7[q])
				+ (dneg_s7[q] ? -$signed(130'(t3_s7[q])) : $signed(130'(t3_s7[q])));
		end
		d_s8 <= d_s7;

		// s9
		for (int q = 0; q < 3; q++) begin
			neg_s9[q] <= n_s8[q][129];
			mag_s9[q] <= n_s8[q][129] ? MAGW'(-n_s8[q]) : n_s8[q][MAGW-1:0];
		end
		d_s9 <= d_s8;
	end

	logic dv [3];

	for (genvar q = 0; q < 3; q++) begin : g_div
		phf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_s9),
			.in_neg    (neg_s9[q]),
			.in_mag    (mag_s9[q]),
			.in_den    (d_s9),
			.out_valid (dv[q]),
			.out_res   (res[q])
		);
	end

	assign out_valid       = dv[0] && dv[1] && dv[2];
	assign mass_flux       = res[0];
	assign x_momentum_flux = res[1];
	assign y_momentum_flux = res[2];
endmodule
`default_nettype wire

/* src/plm_hlle_face_flux_core.sv */
// ----------------------------------------------------------------------------
// plm_hlle_face_flux_core
// Isothermal PLM reconstruction and HLLE flux at one cell face.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// stencil  | start / busy       | 4 cells x (density, vel_x, vel_y)
// flux     | done (strobe)      | mass_flux, x/y_momentum_flux
// config   | cfg_we             | cfg_wdata (sweep direction)
//
// One stencil per cycle. Path: 2 front stages, a queue slot, 9 flux stages and the
// 34-stage divider (an input register, one quotient bit per step, a result register).
// Reset clears all valid state and selects the x sweep.
// busy stays low: the queue drains one entry per cycle and the flux side never stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module plm_hlle_face_flux_core import phf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic [30:0]        far_left_density,
	input  logic signed [31:0] far_left_vel_x,
	input  logic signed [31:0] far_left_vel_y,
	input  logic [30:0]        left_density,
	input  logic signed [31:0] left_vel_x,
	input  logic signed [31:0] left_vel_y,
	input  logic [30:0]        right_density,
	input  logic signed [31:0] right_vel_x,
	input  logic signed [31:0] right_vel_y,
	input  logic [30:0]        far_right_density,
	input  logic signed [31:0] far_right_vel_x,
	input  logic signed [31:0] far_right_vel_y,
	output logic signed [31:0] mass_flux,
	output logic signed [31:0] x_momentum_flux,
	output logic signed [31:0] y_momentum_flux
);
	logic           sweep_dir_q;
	logic           push, pop;
	phf_face_t      push_item, pop_item;
	logic [QLW-1:0] level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_dir_q <= 1'b0;
		end else if (cfg_we) begin
			sweep_dir_q <= cfg_wdata;
		end
	end

	phf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.dir               (sweep_dir_q),
		.far_left_density  (far_left_density),
		.far_left_vel_x    (far_left_vel_x),
		.far_left_vel_y    (far_left_vel_y),
		.left_density      (left_density),
		.left_vel_x        (left_vel_x),
		.left_vel_y        (left_vel_y),
		.right_density     (right_density),
		.right_vel_x       (right_vel_x),
		.right_vel_y       (right_vel_y),
		.far_right_density (far_right_density),
		.far_right_vel_x   (far_right_vel_x),
		.far_right_vel_y   (far_right_vel_y),
		.level             (level),
		.push              (push),
		.item              (push_item)
	);

	phf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.level     (level)
	);

	phf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (pop),
		.in_item         (pop_item),
		.out_valid       (done),
		.mass_flux       (mass_flux),
		.x_momentum_flux (x_momentum_flux),
		.y_momentum_flux (y_momentum_flux)
	);
endmodule
`default_nettype wire
